// File: src/rvl_pkg.sv
// ----------------------------------------------------------------------------
// rvl_pkg
// Shared types and constants of the recent value list.
// ----------------------------------------------------------------------------
package rvl_pkg;

  localparam int DEPTH_DEF      = 4;
  localparam int VALUE_BITS_DEF = 5;
  localparam int REQ_BITS       = 2;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DROP   = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// File: src/rvl_ctrl.sv
// ----------------------------------------------------------------------------
// rvl_ctrl
// Controller: takes a request, issues one execute step, holds the result flag.
// ----------------------------------------------------------------------------
module rvl_ctrl
  import rvl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/rvl_datapath.sv
// ----------------------------------------------------------------------------
// rvl_datapath
// Slot storage, push / lookup / drop logic and the result register.
// ----------------------------------------------------------------------------
module rvl_datapath
  import rvl_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [REQ_BITS-1:0]   in_req_type,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_found_valid,
  output logic [VALUE_BITS-1:0] out_found_value
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [REQ_BITS-1:0]   req_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [VALUE_BITS-1:0] slot_value_r   [DEPTH];
  logic [VALUE_BITS-1:0] slot_value_nxt [DEPTH];
  logic [DEPTH-1:0]      slot_used_r, slot_used_nxt;

  logic                  found_valid_r, found_valid_nxt;
  logic [VALUE_BITS-1:0] found_value_r, found_value_nxt;

  always_comb begin
    logic [IDX_W-1:0]      push_n;
    logic                  push_hit;
    logic                  m_hit;
    logic [IDX_W-1:0]      m_idx;
    logic [DEPTH-1:0]      used2;
    logic [VALUE_BITS-1:0] val2 [DEPTH];
    logic                  hole_hit;
    logic [IDX_W-1:0]      hole;
    logic                  last_hit;
    logic [IDX_W-1:0]      last;

    slot_value_nxt  = slot_value_r;
    slot_used_nxt   = slot_used_r;
    found_valid_nxt = 1'b0;
    found_value_nxt = '0;

    // push: first empty slot, or the last one when full
    push_hit = 1'b0;
    push_n   = IDX_W'(DEPTH - 1);
    for (int i = 0; i < DEPTH; i++) begin
      if (!push_hit && !slot_used_r[i]) begin
        push_hit = 1'b1;
        push_n   = IDX_W'(i);
      end
    end

    // drop: clear first match, then find the first hole and the last used slot behind it
    m_hit = 1'b0;
    m_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!m_hit && slot_used_r[i] && slot_value_r[i] == val_r) begin
        m_hit = 1'b1;
        m_idx = IDX_W'(i);
      end
    end
    used2 = slot_used_r;
    val2  = slot_value_r;
    if (m_hit) begin
      used2[m_idx] = 1'b0;
      val2[m_idx]  = '0;
    end
    hole_hit = 1'b0;
    hole     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!hole_hit && !used2[i]) begin
        hole_hit = 1'b1;
        hole     = IDX_W'(i);
      end
    end
    last_hit = 1'b0;
    last     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hole_hit && IDX_W'(i) > hole && used2[i]) begin
        last_hit = 1'b1;
        last     = IDX_W'(i);
      end
    end

    if (cmd.exec) begin
      case (req_r)
        REQ_PUSH: begin
          for (int i = 1; i < DEPTH; i++) begin
            if (IDX_W'(i) <= push_n) begin
              slot_value_nxt[i] = slot_value_r[i-1];
              slot_used_nxt[i]  = slot_used_r[i-1];
            end
          end
          slot_value_nxt[0] = val_r;
          slot_used_nxt[0]  = 1'b1;
        end
        REQ_LOOKUP: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!found_valid_nxt && slot_used_r[i] && slot_value_r[i] != val_r) begin
              found_valid_nxt = 1'b1;
              found_value_nxt = slot_value_r[i];
            end
          end
        end
        REQ_DROP: begin
          slot_used_nxt  = used2;
          slot_value_nxt = val2;
          if (hole_hit) begin
            if (last_hit) begin
              slot_value_nxt[hole] = val2[last];
              slot_used_nxt[hole]  = 1'b1;
            end
            for (int i = 0; i < DEPTH; i++) begin
              if (IDX_W'(i) > hole) begin
                slot_used_nxt[i]  = 1'b0;
                slot_value_nxt[i] = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        slot_value_r[i] <= '0;
      end
    end else begin
      slot_used_r  <= slot_used_nxt;
      slot_value_r <= slot_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      found_valid_r <= found_valid_nxt;
      found_value_r <= found_value_nxt;
    end
  end

  assign out_found_valid = found_valid_r;
  assign out_found_value = found_value_r;

endmodule

// File: src/recent_value_list_top.sv
// ----------------------------------------------------------------------------
// recent_value_list_top
// Most-recently-used list of small values with push, lookup and drop.
// ----------------------------------------------------------------------------
// Each request is captured in the idle state, then the controller's single
// execute step scans and updates all slots in parallel.
// A new request is taken while the previous result still waits at the output
// register; the execute step waits only while that register holds a result
// that is not taken in the same cycle.
// Every request, push, lookup, drop or unused type, yields exactly one result.
module recent_value_list_top
  import rvl_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_BITS-1:0]   in_req_type,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found_valid,
  output logic [VALUE_BITS-1:0] out_found_value
);

  dp_cmd_t cmd;

  rvl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rvl_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_found_valid (out_found_valid),
    .out_found_value (out_found_value)
  );

endmodule
